// ===== hw/rtl/ata_pkg.sv =====
// Shared types and constants for the address table with aging timers.
// No dependencies; every other file imports this package.
`default_nettype none

package ata_pkg;

  localparam int ADDR_W            = 48;
  localparam int HOLD_W            = 8;
  localparam int STATUS_W          = 2;
  localparam int COUNT_W           = 7;
  localparam int IN_TDATA_W        = 48;
  localparam int OUT_TDATA_W       = 16;
  localparam int CHUNK_W           = 8;
  localparam int CMD_DEPTH         = 2;
  localparam int DEF_TABLE_ENTRIES = 64;

  localparam logic [HOLD_W-1:0]   HOLD_RESET = 8'd60;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = 7'd127;
  localparam logic                KIND_TICK  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_REFRESH = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INSERT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TICK    = 2'd3;

  typedef enum logic {
    OP_SIGHT = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef struct packed {
    logic              valid;
    op_e               op;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ata_front.sv =====
// Front end: accepts input beats, classifies them and queues commands.
// Depends on ata_pkg.
`default_nettype none

module ata_front
  import ata_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,  // [47:0] device_address
  input  wire logic                  s_axis_tuser,  // [0] kind
  input  wire logic                  pop_i,
  output cmd_t                       cmd_o
);

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  op_e               op_mem   [CMD_DEPTH];
  logic [ADDR_W-1:0] addr_mem [CMD_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  op_e               op_in;
  logic              push;
  logic              pop;

  always_comb begin
    unique case (s_axis_tuser)
      KIND_TICK: op_in = OP_TICK;
      default:   op_in = OP_SIGHT;
    endcase
  end

  assign s_axis_tready = (cnt_q != CNT_W'(CMD_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_mem[wr_ptr_q]   <= op_in;
      addr_mem[wr_ptr_q] <= s_axis_tdata[ADDR_W-1:0];
    end
  end

  assign cmd_o.valid = (cnt_q != '0);
  assign cmd_o.op    = op_mem[rd_ptr_q];
  assign cmd_o.addr  = addr_mem[rd_ptr_q];

endmodule

`default_nettype wire

// ===== hw/rtl/ata_back.sv =====
// Back end: address table, aging timers, search, update and live count.
// Depends on ata_pkg; fed by ata_front through the command queue.
`default_nettype none

module ata_back
  import ata_pkg::*;
#(
  parameter int TableEntries = DEF_TABLE_ENTRIES
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [HOLD_W-1:0]      hold_i,
  input  wire cmd_t                   cmd_i,
  output logic                        pop_o,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata  // [1:0] status, [8:2] live_count
);

  localparam int CHUNKS = (TableEntries + CHUNK_W - 1) / CHUNK_W;
  localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CNT_W  = $clog2(TableEntries + 1);
  localparam int SAT_W  = 9;
  localparam int PC_W   = $clog2(CHUNK_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_CNT  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]              state_q, state_d;
  cmd_t                    cur_q;
  logic [ADDR_W-1:0]       addr_q [TableEntries];
  logic [TableEntries-1:0] wr_q;
  logic [HOLD_W-1:0]       tmr_q  [TableEntries];
  logic [TableEntries-1:0] match_d, free_d;
  logic [TableEntries-1:0] match_q, free_q;
  logic [TableEntries-1:0] msel_q, fsel_q;
  logic                    hit_q, room_q;
  logic [STATUS_W-1:0]     status_q;
  logic [CNT_W-1:0]        count_q;
  logic [CH_W-1:0]         chunk_q;
  logic [CHUNKS*CHUNK_W-1:0] live_pad;
  logic [CHUNK_W-1:0]      live_chunk;
  logic [PC_W-1:0]         chunk_pop;
  logic [SAT_W-1:0]        count_ext;
  logic [COUNT_W-1:0]      count_sat;
  logic                    out_valid_q;
  logic [STATUS_W-1:0]     out_status_q;
  logic [COUNT_W-1:0]      out_count_q;
  logic                    out_free;

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      match_d[i] = ((wr_q[i] ? addr_q[i] : '0) == cur_q.addr);
      free_d[i]  = (tmr_q[i] == '0);
    end
  end

  always_comb begin
    live_pad = '0;
    for (int i = 0; i < TableEntries; i++) begin
      live_pad[i] = (tmr_q[i] != '0);
    end
  end

  assign live_chunk = live_pad[chunk_q*CHUNK_W +: CHUNK_W];

  always_comb begin
    chunk_pop = '0;
    for (int j = 0; j < CHUNK_W; j++) begin
      chunk_pop = chunk_pop + PC_W'(live_chunk[j]);
    end
  end

  assign count_ext = SAT_W'(count_q);
  assign count_sat = (count_ext > SAT_W'(COUNT_MAX)) ? COUNT_MAX : count_ext[COUNT_W-1:0];
  assign out_free  = !out_valid_q || m_axis_tready;
  assign pop_o     = (state_q == S_IDLE) && cmd_i.valid;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_i.valid) state_d = S_CMP;
      S_CMP:  state_d = S_PICK;
      S_PICK: state_d = S_UPD;
      S_UPD:  state_d = S_CNT;
      S_CNT:  if (chunk_q == CH_W'(CHUNKS - 1)) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TableEntries; i++) begin
        tmr_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_UPD) begin
        for (int i = 0; i < TableEntries; i++) begin
          if (cur_q.op == OP_TICK) begin
            if (tmr_q[i] != '0) begin
              tmr_q[i] <= tmr_q[i] - 1'b1;
            end
          end else if (hit_q) begin
            if (msel_q[i]) begin
              tmr_q[i] <= hold_i;
            end
          end else if (fsel_q[i]) begin
            tmr_q[i] <= hold_i;
            wr_q[i]  <= 1'b1;
          end
        end
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= cmd_i;
    end
    if (state_q == S_CMP) begin
      match_q <= match_d;
      free_q  <= free_d;
    end
    if (state_q == S_PICK) begin
      msel_q <= match_q & (~match_q + TableEntries'(1));
      fsel_q <= free_q & (~free_q + TableEntries'(1));
      hit_q  <= |match_q;
      room_q <= |free_q;
    end
    if (state_q == S_UPD) begin
      if (cur_q.op == OP_TICK) begin
        status_q <= ST_TICK;
      end else if (hit_q) begin
        status_q <= ST_REFRESH;
      end else if (room_q) begin
        status_q <= ST_INSERT;
      end else begin
        status_q <= ST_FULL;
      end
      for (int i = 0; i < TableEntries; i++) begin
        if ((cur_q.op == OP_SIGHT) && !hit_q && fsel_q[i]) begin
          addr_q[i] <= cur_q.addr;
        end
      end
      count_q <= '0;
      chunk_q <= '0;
    end
    if (state_q == S_CNT) begin
      count_q <= count_q + CNT_W'(chunk_pop);
      chunk_q <= chunk_q + 1'b1;
    end
    if ((state_q == S_OUT) && out_free) begin
      out_status_q <= status_q;
      out_count_q  <= count_sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - COUNT_W - STATUS_W){1'b0}}, out_count_q, out_status_q};

endmodule

`default_nettype wire

// ===== hw/rtl/address_table_with_aging_top.sv =====
// In the back end each beat takes these steps in order: take a command, compare the address
// against every entry, pick the lowest hit and lowest free slot, update, count live timers
// eight entries at a time, then load the output register once it is free. A two-deep
// command queue lets input beats arrive while an item is in work, and a result waiting at
// the output does not stop the next beat from being accepted. hold_ticks resets to 60 and
// is written through cfg_we_i.
//
// Top level of the address table with aging timers.
// Depends on ata_pkg, ata_front and ata_back.
`default_nettype none

module address_table_with_aging_top
  import ata_pkg::*;
#(
  parameter int TableEntries = DEF_TABLE_ENTRIES
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [HOLD_W-1:0]      cfg_wdata_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [47:0] device_address
  input  wire logic                   s_axis_tuser,  // [0] kind
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata   // [1:0] status, [8:2] live_count
);

  logic [HOLD_W-1:0] hold_q;
  cmd_t              cmd;
  logic              cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HOLD_RESET;
    end else if (cfg_we_i) begin
      hold_q <= cfg_wdata_i;
    end
  end

  ata_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .pop_i (cmd_pop),
    .cmd_o (cmd)
  );

  ata_back #(
    .TableEntries (TableEntries)
  ) u_back (
    .clk_i,
    .rst_ni,
    .hold_i (hold_q),
    .cmd_i  (cmd),
    .pop_o  (cmd_pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

`ifndef SYNTHESIS
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd.valid)
    else $error("command popped from empty queue");

  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> cmd.valid)
    else $error("accepted beat missing from command queue");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |=> !cmd_pop)
    else $error("back end took two commands in a row");
`endif

endmodule

`default_nettype wire
